// ===== sv/biq_pkg.sv =====
package biq_pkg;

    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;
    localparam int APB_AW    = REG_IDX_W + 2;
    localparam int APB_DW    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

endpackage

// ===== sv/biquad_iir_lowpass.sv =====
// A word accepted into the input register goes to o_filtered through the output register.
// Throughput: one word per cycle while i_stall does not hold the output; the five
// products and their sum fit between the input register and the output register,
// and the feedback history updates at the same edge that loads the output register.
// Reset (synchronous, active low) clears both histories and the valid flags and
// loads b0 with unity gain and the other coefficients with zero.
module biquad_iir_lowpass #(
    parameter int DATA_WIDTH = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [DATA_WIDTH-1:0]     i_sample,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [DATA_WIDTH-1:0]     o_filtered,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [biq_pkg::APB_AW-1:0]       paddr,
    input  logic [biq_pkg::APB_DW-1:0]       pwdata,
    output logic [biq_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import biq_pkg::*;

    logic [NUM_REGS-1:0][COEF_WIDTH-1:0] w_coef;

    logic                         r_in_vld, n_in_vld;
    logic signed [DATA_WIDTH-1:0] r_in_x;
    logic                         r_out_vld, n_out_vld;
    logic signed [DATA_WIDTH-1:0] r_out_y;
    logic signed [DATA_WIDTH-1:0] w_y;
    logic                         w_adv;
    logic                         w_acc_in;

    biq_cfg_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    biq_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_x     (r_in_x),
        .i_coef  (w_coef),
        .o_y     (w_y)
    );

    // The held word moves on whenever the output register is free or being drained.
    assign w_adv      = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall    = r_in_vld && !w_adv;
    assign w_acc_in   = i_valid && !o_stall;
    assign o_valid    = r_out_vld;
    assign o_filtered = r_out_y;

    always_comb begin
        n_in_vld  = w_acc_in || (r_in_vld && !w_adv);
        n_out_vld = w_adv || (r_out_vld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_in_x <= i_sample;
        end
        if (w_adv) begin
            r_out_y <= w_y;
        end
    end

endmodule

// ===== sv/biq_cfg_regs.sv =====
module biq_cfg_regs #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [biq_pkg::APB_AW-1:0]                     paddr,
    input  logic [biq_pkg::APB_DW-1:0]                     pwdata,
    output logic [biq_pkg::APB_DW-1:0]                     prdata,
    output logic                                           pready,
    output logic [biq_pkg::NUM_REGS-1:0][COEF_WIDTH-1:0]   o_coef
);
    import biq_pkg::*;

    // Unity gain in the coefficient format, two integer bits.
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {(COEF_WIDTH-2){1'b0}}};
    // b0 sits in the lowest slot and starts at unity gain; the rest start at zero.
    localparam logic [NUM_REGS-1:0][COEF_WIDTH-1:0] COEF_RST =
        {{((NUM_REGS-1)*COEF_WIDTH){1'b0}}, COEF_ONE};

    logic [NUM_REGS-1:0][COEF_WIDTH-1:0] r_coef;
    logic [NUM_REGS-1:0][COEF_WIDTH-1:0] n_coef;
    logic [REG_IDX_W-1:0]                w_idx;
    logic                                w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_coef = r_coef;

    always_comb begin
        n_coef = r_coef;
        if (w_wr) begin
            unique case (t_reg_idx'(w_idx)) inside
                REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
                    n_coef[w_idx] = pwdata[COEF_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(w_idx)) inside
            REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
                prdata = APB_DW'($signed(r_coef[w_idx]));
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else begin
            r_coef <= n_coef;
        end
    end

endmodule

// ===== sv/biq_datapath.sv =====
module biq_datapath #(
    parameter int DATA_WIDTH = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  logic signed [DATA_WIDTH-1:0]                   i_x,
    input  logic [biq_pkg::NUM_REGS-1:0][COEF_WIDTH-1:0]   i_coef,
    output logic signed [DATA_WIDTH-1:0]                   o_y
);
    import biq_pkg::*;

    localparam int FRAC = COEF_WIDTH - 2;
    localparam int PW   = DATA_WIDTH + COEF_WIDTH;
    // Five products and the rounding term cannot overflow four guard bits.
    localparam int AW   = PW + 4;
    localparam int SW   = AW - FRAC;

    localparam logic signed [AW-1:0] RND  =
        {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [SW-1:0] MAXV =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [PW-1:0]         w_p_b0, w_p_b1, w_p_b2, w_p_a1, w_p_a2;
    logic signed [AW-1:0]         w_acc;
    logic signed [SW-1:0]         w_sh;

    assign w_p_b0 = $signed(i_coef[REG_B0]) * i_x;
    assign w_p_b1 = $signed(i_coef[REG_B1]) * r_x1;
    assign w_p_b2 = $signed(i_coef[REG_B2]) * r_x2;
    assign w_p_a1 = $signed(i_coef[REG_A1]) * r_y1;
    assign w_p_a2 = $signed(i_coef[REG_A2]) * r_y2;

    assign w_acc = AW'(w_p_b0) + AW'(w_p_b1) + AW'(w_p_b2)
                 - AW'(w_p_a1) - AW'(w_p_a2) + RND;

    // Dropping the fraction bits of a two's complement value floors it.
    assign w_sh = $signed(w_acc[AW-1:FRAC]);

    always_comb begin
        if (w_sh > MAXV) begin
            o_y = MAXV[DATA_WIDTH-1:0];
        end else if (w_sh < MINV) begin
            o_y = MINV[DATA_WIDTH-1:0];
        end else begin
            o_y = w_sh[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_adv) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_y1 <= o_y;
            r_y2 <= r_y1;
        end
    end

endmodule
